// ===== src/lerb_pkg.sv =====
// Shared constants, codes and types of the line-editing receive buffer.
`default_nettype none

package lerb_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // A line holds at most STORE_DEPTH-1 bytes including its newline.
  localparam int LEN_W       = ADDR_W;
  localparam int CNT_W       = 7;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ETB = 8'h17;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ECHO  = 3'd1,
    KIND_BELL  = 3'd2,
    KIND_ERASE = 3'd3,
    KIND_CRLF  = 3'd4
  } tx_kind_t;

  typedef struct packed {
    tx_kind_t               tx_kind;
    logic [7:0]             tx_byte;
    logic [CNT_W-1:0]       erase_count;
    logic                   read_valid;
    logic [7:0]             read_byte;
    logic                   read_last;
    logic                   rx_refused;
  } lerb_res_t;

endpackage

`default_nettype wire

// ===== src/lerb_line_ram.sv =====
// Line store: one write port, one registered read port.
`default_nettype none

module lerb_line_ram import lerb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lerb_seq.sv =====
// Editing sequencer: decodes an item, walks the store for word erase, drains lines.
`default_nettype none

module lerb_seq import lerb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   busy,
  output logic                   res_valid,
  input  wire logic              res_take,
  output lerb_res_t              res,
  output logic                   ram_we,
  output logic      [ADDR_W-1:0] ram_waddr,
  output logic      [7:0]        ram_wdata,
  output logic                   ram_re,
  output logic      [ADDR_W-1:0] ram_raddr,
  input  wire logic [7:0]        ram_rdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic             act_r, act_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             cmpl_r, cmpl_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  lerb_res_t        res_r, res_nxt;

  logic [LEN_W:0]   pos_inc;
  logic [LEN_W-1:0] len_dec;
  logic [LEN_W-1:0] cnt_inc;
  logic             blank;

  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  assign pos_inc = {1'b0, pos_r} + 1'b1;
  assign len_dec = len_r - 1'b1;
  assign cnt_inc = cnt_r + 1'b1;
  assign blank   = is_blank(ram_rdata);

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    byte_nxt  = byte_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    cmpl_nxt  = cmpl_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = len_r[ADDR_W-1:0];
    ram_wdata = byte_r;
    ram_re    = 1'b0;
    ram_raddr = len_dec[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          byte_nxt  = in_rx_byte;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        if (!act_r) begin
          if (cmpl_r) begin
            res_nxt.rx_refused = 1'b1;
          end else begin
            case (byte_r)
              CH_CR: begin
                ram_we          = 1'b1;
                ram_wdata       = CH_LF;
                len_nxt         = len_r + 1'b1;
                pos_nxt         = '0;
                cmpl_nxt        = 1'b1;
                res_nxt.tx_kind = KIND_CRLF;
              end
              CH_BS, CH_DEL: begin
                if (len_r == '0) begin
                  res_nxt.tx_kind = KIND_BELL;
                end else begin
                  len_nxt             = len_dec;
                  res_nxt.erase_count = CNT_W'(1);
                  res_nxt.tx_kind     = KIND_ERASE;
                end
              end
              CH_ETB: begin
                cnt_nxt = '0;
                if (len_r != '0) begin
                  ram_re    = 1'b1;
                  state_nxt = S_SCAN;
                end
              end
              CH_NAK: begin
                len_nxt             = '0;
                res_nxt.erase_count = CNT_W'(len_r);
                res_nxt.tx_kind     = (len_r != '0) ? KIND_ERASE : KIND_NONE;
              end
              default: begin
                if (len_r >= LEN_W'(STORE_DEPTH - 2)) begin
                  res_nxt.tx_kind = KIND_BELL;
                end else begin
                  ram_we          = 1'b1;
                  len_nxt         = len_r + 1'b1;
                  res_nxt.tx_kind = KIND_ECHO;
                  res_nxt.tx_byte = byte_r;
                end
              end
            endcase
          end
        end else if (cmpl_r) begin
          ram_re    = 1'b1;
          ram_raddr = pos_r[ADDR_W-1:0];
          state_nxt = S_RDWAIT;
        end
      end
      S_SCAN: begin
        // ram_rdata holds the character at len_r-1
        if (blank) begin
          res_nxt.erase_count = CNT_W'(cnt_r);
          res_nxt.tx_kind     = (cnt_r != '0) ? KIND_ERASE : KIND_NONE;
          state_nxt           = S_DONE;
        end else begin
          len_nxt = len_dec;
          cnt_nxt = cnt_inc;
          if (len_r == LEN_W'(1)) begin
            res_nxt.erase_count = CNT_W'(cnt_inc);
            res_nxt.tx_kind     = KIND_ERASE;
            state_nxt           = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = len_dec[ADDR_W-1:0] - 1'b1;
          end
        end
      end
      S_RDWAIT: begin
        res_nxt.read_valid = 1'b1;
        res_nxt.read_byte  = ram_rdata;
        pos_nxt            = pos_inc[LEN_W-1:0];
        if (pos_inc >= {1'b0, len_r}) begin
          res_nxt.read_last = 1'b1;
          len_nxt           = '0;
          pos_nxt           = '0;
          cmpl_nxt          = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pos_r   <= '0;
      cmpl_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      cmpl_r  <= cmpl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    byte_r <= byte_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== src/line_editing_receive_buffer.sv =====
// Top level of the line-editing receive buffer: sequencer, line store and output register.
`default_nettype none

// One item is taken at a time and gives exactly one result. A received byte or
// a read is decoded first, and a line read then adds a store read. Word erase
// (^W) walks the line store backward through its single read port, one
// character per cycle. The next item can be taken as soon as the result sits
// in the output register, even if the receiver is still stalling it.
module line_editing_receive_buffer import lerb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_action,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [2:0]       out_tx_kind,
  output logic      [7:0]       out_tx_byte,
  output logic      [CNT_W-1:0] out_erase_count,
  output logic                  out_read_valid,
  output logic      [7:0]       out_read_byte,
  output logic                  out_read_last,
  output logic                  out_rx_refused
);

  logic              busy;
  logic              res_valid;
  logic              res_take;
  lerb_res_t         res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              out_valid_r, out_valid_nxt;
  lerb_res_t         out_r;

  lerb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  lerb_line_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result moves into the output register when it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign in_stall        = busy;
  assign out_valid       = out_valid_r;
  assign out_tx_kind     = out_r.tx_kind;
  assign out_tx_byte     = out_r.tx_byte;
  assign out_erase_count = out_r.erase_count;
  assign out_read_valid  = out_r.read_valid;
  assign out_read_byte   = out_r.read_byte;
  assign out_read_last   = out_r.read_last;
  assign out_rx_refused  = out_r.rx_refused;

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid)
    else $error("result taken but output not valid");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer taken while item in flight");

  a_read_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> (out_tx_kind == KIND_NONE && !out_rx_refused))
    else $error("line read result carries transmit action");

  a_last_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_last) |-> (out_read_valid && out_read_byte == CH_LF))
    else $error("last flag without final newline");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the line-editing receive buffer.
`timescale 1ns / 1ps

module tb;
  import lerb_pkg::*;

  localparam int TOTAL_ITEMS  = 550;
  localparam int PAUSE_AT     = 330;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT      = 60;
  localparam int TAIL_CYCLES  = 150;
  localparam int CALM_ITEMS   = 64;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic       act;
    logic [7:0] ch;
  } serial_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_action = 1'b0;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_tx_kind;
  logic [7:0]       out_tx_byte;
  logic [CNT_W-1:0] out_erase_count;
  logic             out_read_valid;
  logic [7:0]       out_read_byte;
  logic             out_read_last;
  logic             out_rx_refused;

  line_editing_receive_buffer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tx_kind     (out_tx_kind),
    .out_tx_byte     (out_tx_byte),
    .out_erase_count (out_erase_count),
    .out_read_valid  (out_read_valid),
    .out_read_byte   (out_read_byte),
    .out_read_last   (out_read_last),
    .out_rx_refused  (out_rx_refused)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the line buffer state
  logic [7:0] line_mem [STORE_DEPTH];
  logic [6:0] line_len;
  logic [6:0] rd_pos;
  logic       line_done;

  serial_item_t send_q [$];
  lerb_res_t    result_q [$];
  serial_item_t next_item;
  lerb_res_t    want;

  logic in_taken = 1'b0;
  bit   gen_done = 1'b0;
  bit   hold_done = 1'b0;
  int   send_gap = 0;
  int   stall_cnt = 0;
  int   hold_cnt = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   n_fail = 0;
  int   cycles = 0;

  function automatic lerb_res_t edit_line(logic act, logic [7:0] c);
    lerb_res_t r;
    r = '0;
    if (!act) begin
      if (line_done) begin
        r.rx_refused = 1'b1;
      end else if (c == CH_CR) begin
        line_mem[line_len] = CH_LF;
        line_len = line_len + 1'b1;
        rd_pos = '0;
        line_done = 1'b1;
        r.tx_kind = KIND_CRLF;
      end else if (c == CH_BS || c == CH_DEL) begin
        if (line_len == 0) begin
          r.tx_kind = KIND_BELL;
        end else begin
          line_len = line_len - 1'b1;
          r.erase_count = CNT_W'(1);
          r.tx_kind = KIND_ERASE;
        end
      end else if (c == CH_ETB) begin
        // strip trailing non-blank characters (HT..CR and SP count as blank)
        while (line_len != 0 && !(line_mem[line_len-1] == 8'h20 ||
               (line_mem[line_len-1] >= 8'h09 && line_mem[line_len-1] <= 8'h0D))) begin
          line_len = line_len - 1'b1;
          r.erase_count = r.erase_count + 1'b1;
        end
        if (r.erase_count != 0) r.tx_kind = KIND_ERASE;
      end else if (c == CH_NAK) begin
        r.erase_count = line_len;
        line_len = '0;
        if (r.erase_count != 0) r.tx_kind = KIND_ERASE;
      end else if (line_len >= STORE_DEPTH - 2) begin
        r.tx_kind = KIND_BELL;
      end else begin
        line_mem[line_len] = c;
        line_len = line_len + 1'b1;
        r.tx_kind = KIND_ECHO;
        r.tx_byte = c;
      end
    end else if (line_done) begin
      r.read_valid = 1'b1;
      r.read_byte = line_mem[rd_pos];
      rd_pos = rd_pos + 1'b1;
      if (rd_pos >= line_len) begin
        r.read_last = 1'b1;
        line_len = '0;
        rd_pos = '0;
        line_done = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic bit tail_phase();
    return gen_done && send_q.size() < CALM_ITEMS;
  endfunction

  // Any byte that is not an editing command; optionally excluding blanks
  function automatic logic [7:0] plain_char(bit nonblank);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_CR || c == CH_BS || c == CH_DEL || c == CH_ETB || c == CH_NAK ||
               (nonblank && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))));
    return c;
  endfunction

  task automatic push_item(logic act, logic [7:0] c);
    serial_item_t it;
    it.act = act;
    it.ch = c;
    send_q.push_back(it);
    n_items++;
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Sender: new transfer only when the previous one went through
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (send_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!tail_phase() && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 15);
      end else begin
        next_item = send_q.pop_front();
        in_valid <= 1'b1;
        in_action <= next_item.act;
        in_rx_byte <= next_item.ch;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_cnt <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (stall_cnt != 0) begin
      out_stall <= 1'b1;
      stall_cnt <= stall_cnt - 1;
    end else if (!tail_phase() && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_cnt <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) result_q.push_back(edit_line(in_action, in_rx_byte));
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: result with nothing expected, kind %h", $time, out_tx_kind);
        n_fail++;
      end else begin
        want = result_q.pop_front();
        check_field("tx_kind", 8'(want.tx_kind), 8'(out_tx_kind));
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("erase_count", 8'(want.erase_count), 8'(out_erase_count));
        check_field("read_valid", 8'(want.read_valid), 8'(out_read_valid));
        check_field("read_byte", want.read_byte, out_read_byte);
        check_field("read_last", 8'(want.read_last), 8'(out_read_last));
        check_field("rx_refused", 8'(want.rx_refused), 8'(out_rx_refused));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int guess;
    int n;
    bit paused;
    line_len = '0;
    rd_pos = '0;
    line_done = 1'b0;
    guess = 0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-line cases, word/char/line erase, refusal, readout
    push_item(1'b1, 8'hFF);
    push_item(1'b0, CH_BS);
    push_item(1'b0, CH_DEL);
    push_item(1'b0, CH_ETB);
    push_item(1'b0, CH_NAK);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h61);
    push_item(1'b0, 8'h09);
    push_item(1'b0, 8'h62);
    push_item(1'b0, 8'h63);
    push_item(1'b0, CH_ETB);
    push_item(1'b0, CH_DEL);
    push_item(1'b0, CH_BS);
    push_item(1'b0, CH_NAK);
    push_item(1'b0, 8'h78);
    push_item(1'b0, 8'h20);
    push_item(1'b0, 8'h79);
    push_item(1'b0, CH_CR);
    push_item(1'b0, 8'h7A);
    push_item(1'b0, CH_CR);
    repeat (4) push_item(1'b1, 8'h00);
    push_item(1'b1, 8'h00);
    wait_drained();

    // full line: last byte rings the bell, then one word erase clears it all
    repeat (STORE_DEPTH - 1) push_item(1'b0, plain_char(1'b1));
    push_item(1'b0, CH_ETB);

    while (n_items < TOTAL_ITEMS) begin
      if (!paused && n_items >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        guess += n;
      end else begin
        repeat ($urandom_range(0, 16)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              push_item(1'b0, plain_char(1'b1));
              guess++;
            end
            6: begin
              case ($urandom_range(0, 4))
                0: push_item(1'b0, 8'h09);
                1: push_item(1'b0, CH_LF);
                2: push_item(1'b0, 8'h0B);
                3: push_item(1'b0, 8'h0C);
                default: push_item(1'b0, 8'h20);
              endcase
              guess++;
            end
            7: push_item(1'b0, ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL);
            8: push_item(1'b0, CH_ETB);
            default: begin
              push_item(1'b0, CH_NAK);
              guess = 0;
            end
          endcase
        end
        if ($urandom_range(0, 4) != 0) begin
          push_item(1'b0, CH_CR);
          if ($urandom_range(0, 3) == 0) push_item(1'b0, 8'($urandom_range(0, 255)));
          if (guess > STORE_DEPTH - 1) guess = STORE_DEPTH - 1;
          repeat (guess + 1 + $urandom_range(0, 1))
            push_item(1'b1, 8'($urandom_range(0, 255)));
          guess = 0;
        end
      end
    end
    gen_done = 1'b1;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
